// ===== rtl/psg_pkg.sv =====
// Shared types and constants of the prime sequence generator.
package psg_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int FIELD_WIDTH = 32;
	localparam int COUNT_WIDTH = 7;
	localparam int MAX_COUNT   = 64;

	// Divisors never exceed 2^(VALUE_WIDTH/2)+1, so one extra bit is enough.
	localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 1;
	localparam int SQ_WIDTH  = VALUE_WIDTH + 2;
	localparam int BIT_WIDTH = $clog2(VALUE_WIDTH);

	localparam logic [VALUE_WIDTH-1:0] VAL_LIMIT = {VALUE_WIDTH{1'b1}} - VALUE_WIDTH'(2);
	localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = COUNT_WIDTH'(MAX_COUNT);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_TINIT,
		S_TCHK,
		S_DIV,
		S_RCHK,
		S_STEP,
		S_NEXT,
		S_OUT
	} psg_state_t;

	typedef struct packed {
		logic load;
		logic make_odd;
		logic add2;
		logic set_small;
		logic tinit;
		logic div_start;
		logic div_step;
		logic next_div;
	} psg_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_gt_two;
		logic n_near_max;
		logic dsq_gt_n;
		logic div_done;
		logic rem_zero;
	} psg_status_t;

endpackage

// ===== rtl/psg_datapath.sv =====
// Candidate register, divisor and square tracking, and the bit-serial remainder unit.
module psg_datapath (
	input  logic                            clk,
	input  logic [psg_pkg::FIELD_WIDTH-1:0] start_value,
	input  psg_pkg::psg_cmd_t               cmd,
	output psg_pkg::psg_status_t            status,
	output logic [psg_pkg::VALUE_WIDTH-1:0] n_value
);
	import psg_pkg::*;

	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] nsh_q;
	logic [DIV_WIDTH-1:0]   d_q;
	logic [DIV_WIDTH-1:0]   rem_q;
	logic [SQ_WIDTH-1:0]    dsq_q;
	logic [BIT_WIDTH-1:0]   bit_q;

	logic [DIV_WIDTH:0]     rem_sh;
	logic [DIV_WIDTH:0]     rem_diff;
	logic                   rem_ge;

	assign rem_sh   = {rem_q, nsh_q[VALUE_WIDTH-1]};
	assign rem_diff = rem_sh - {1'b0, d_q};
	assign rem_ge   = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= VALUE_WIDTH'(start_value);
		end else if (cmd.make_odd) begin
			// An even start other than two moves up to the next odd value.
			if (!n_q[0] && n_q != VALUE_WIDTH'(2)) begin
				n_q <= n_q + VALUE_WIDTH'(1);
			end
		end else if (cmd.add2) begin
			n_q <= n_q + VALUE_WIDTH'(2);
		end else if (cmd.set_small) begin
			n_q <= (n_q == VALUE_WIDTH'(2)) ? VALUE_WIDTH'(3) : VALUE_WIDTH'(2);
		end

		if (cmd.tinit) begin
			d_q   <= DIV_WIDTH'(3);
			dsq_q <= SQ_WIDTH'(9);
		end else if (cmd.next_div) begin
			// (d+2)^2 = d^2 + 4d + 4
			d_q   <= d_q + DIV_WIDTH'(2);
			dsq_q <= dsq_q + SQ_WIDTH'({d_q, 2'b00}) + SQ_WIDTH'(4);
		end

		if (cmd.div_start) begin
			nsh_q <= n_q;
			rem_q <= '0;
			bit_q <= '0;
		end else if (cmd.div_step) begin
			nsh_q <= {nsh_q[VALUE_WIDTH-2:0], 1'b0};
			rem_q <= rem_ge ? rem_diff[DIV_WIDTH-1:0] : rem_sh[DIV_WIDTH-1:0];
			bit_q <= bit_q + BIT_WIDTH'(1);
		end
	end

	assign status.n_zero     = n_q == '0;
	assign status.n_gt_two   = n_q > VALUE_WIDTH'(2);
	assign status.n_near_max = n_q > VAL_LIMIT;
	assign status.dsq_gt_n   = dsq_q > SQ_WIDTH'(n_q);
	assign status.div_done   = bit_q == BIT_WIDTH'(VALUE_WIDTH - 1);
	assign status.rem_zero   = rem_q == '0;

	assign n_value = n_q;

endmodule

// ===== rtl/psg_ctrl.sv =====
// Controller state machine: start settling, prime search sequencing and result handshake.
module psg_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [psg_pkg::COUNT_WIDTH-1:0] prime_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            last,
	output logic                            overflow,
	input  psg_pkg::psg_status_t            status,
	output psg_pkg::psg_cmd_t               cmd
);
	import psg_pkg::*;

	psg_state_t             state_q, state_d;
	logic                   adv_q, adv_d;
	logic                   ovf_q, ovf_d;
	logic [COUNT_WIDTH-1:0] left_q, left_d;
	logic [COUNT_WIDTH-1:0] count_sat;

	assign count_sat = (prime_count > COUNT_SAT) ? COUNT_SAT : prime_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			adv_q   <= 1'b0;
			ovf_q   <= 1'b0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			adv_q   <= adv_d;
			ovf_q   <= ovf_d;
			left_q  <= left_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		adv_d     = adv_q;
		ovf_d     = ovf_q;
		left_d    = left_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		last      = ovf_q || left_q == COUNT_WIDTH'(1);
		overflow  = ovf_q;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					adv_d    = 1'b0;
					ovf_d    = 1'b0;
					left_d   = count_sat;
					// A request for zero primes produces nothing.
					if (count_sat != '0) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				if (status.n_zero) begin
					state_d = S_NEXT;
				end else begin
					cmd.make_odd = 1'b1;
					state_d      = S_TINIT;
				end
			end
			S_TINIT: begin
				cmd.tinit = 1'b1;
				state_d   = S_TCHK;
			end
			S_TCHK: begin
				if (status.dsq_gt_n) begin
					// No divisor found: the candidate is prime.
					state_d = adv_q ? S_OUT : S_NEXT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = S_RCHK;
				end
			end
			S_RCHK: begin
				if (status.rem_zero) begin
					state_d = S_STEP;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = S_TCHK;
				end
			end
			S_STEP: begin
				if (status.n_near_max) begin
					ovf_d   = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.add2 = 1'b1;
					state_d  = S_TINIT;
				end
			end
			S_NEXT: begin
				adv_d = 1'b1;
				if (status.n_gt_two) begin
					state_d = S_STEP;
				end else begin
					cmd.set_small = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (last) begin
						state_d = S_IDLE;
					end else begin
						left_d  = left_q - COUNT_WIDTH'(1);
						state_d = S_NEXT;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/prime_sequence_generator.sv =====
// Top level of the prime sequence generator: controller, datapath and checks.
//
// A request on the input channel (start_value, prime_count) starts a run of
// prime_count primes, at most 64, each the next prime after the previous one.
// The start is first settled onto a prime (one counts as prime) and is not
// itself emitted; a start of zero gives 2, 3, 5 and so on. The final result
// of a run has last set. When no further prime fits in 32 bits, a result with
// prime_value 0, last and overflow set ends the run early.
// A request for zero primes is accepted and produces no result.
// One request is processed at a time: in_ready is high only while idle.
// Every candidate is tested by odd trial division with one remainder unit that
// retires one quotient bit per cycle; each divisor takes a bound check, a
// shift step per candidate bit and a remainder check, each further candidate
// also passes the step and divisor-init states, and a prime ends with one
// final bound check.
// Each result is held on the ports while out_ready is low, and the search
// for the next prime waits until the result is taken.
// Reset returns the controller to idle; the datapath holds no state that
// needs clearing.
module prime_sequence_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] start_value,
	input  logic [6:0]  prime_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] prime_value,
	output logic        last,
	output logic        overflow
);
	import psg_pkg::*;

	psg_cmd_t               cmd;
	psg_status_t            status;
	logic [VALUE_WIDTH-1:0] n_value;

	psg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.prime_count (prime_count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.last        (last),
		.overflow    (overflow),
		.status      (status),
		.cmd         (cmd)
	);

	psg_datapath u_datapath (
		.clk         (clk),
		.start_value (start_value),
		.cmd         (cmd),
		.status      (status),
		.n_value     (n_value)
	);

	assign prime_value = overflow ? '0 : FIELD_WIDTH'(n_value);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> last && prime_value == '0)
		else $error("overflow result does not end the run with a zero value");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready && !out_valid)
		else $error("block not idle after the final result");

	a_result_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overflow && prime_value != 32'd2 |-> prime_value[0])
		else $error("emitted prime other than two is even");

endmodule

// ===== sim/prime_sequence_generator_tb.sv =====
// Self-checking testbench for the prime sequence generator with randomized handshakes.
`timescale 1ns / 1ps

module prime_sequence_generator_tb;
	import psg_pkg::*;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] value;
		logic                   last;
		logic                   overflow;
	} prime_result_t;

	localparam logic [63:0] VALUE_MAX = (VALUE_WIDTH >= 64) ? {64{1'b1}} :
		((64'd1 << VALUE_WIDTH) - 64'd1);
	localparam int LONG_HOLD_CYCLES = 600;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [31:0] start_value;
	logic [COUNT_WIDTH-1:0] prime_count;
	logic out_valid;
	logic out_ready;
	logic [31:0] prime_value;
	logic last;
	logic overflow;

	prime_result_t expected_primes[$];
	int error_count = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit long_hold = 1'b0;

	prime_sequence_generator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_value (start_value),
		.prime_count (prime_count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.prime_value (prime_value),
		.last        (last),
		.overflow    (overflow)
	);

	always #2 clk = ~clk;

	// Trial division by 2, 3 and then 6k-1 / 6k+1 divisors; one passes.
	function automatic bit passes_six_test(logic [63:0] n);
		logic [63:0] d;
		logic [63:0] w;
		if (n == 64'd2 || n == 64'd3) return 1'b1;
		if (n[0] == 1'b0) return 1'b0;
		if (n % 64'd3 == 64'd0) return 1'b0;
		d = 64'd5;
		w = 64'd2;
		while (d <= n / d) begin
			if (n % d == 64'd0) return 1'b0;
			d = d + w;
			w = 64'd6 - w;
		end
		return 1'b1;
	endfunction

	function automatic bit passes_odd_test(logic [63:0] n);
		logic [63:0] d;
		for (d = 64'd3; d <= n / d; d = d + 64'd2)
			if (n % d == 64'd0) return 1'b0;
		return 1'b1;
	endfunction

	// Returns zero when no further prime fits in the value width.
	function automatic logic [63:0] next_prime_after(logic [63:0] n);
		if (n > 64'd2) begin
			do begin
				if (n > VALUE_MAX - 64'd2) return 64'd0;
				n = n + 64'd2;
			end while (!passes_odd_test(n));
			return n;
		end
		return (n == 64'd2) ? 64'd3 : 64'd2;
	endfunction

	function automatic void predict_run(logic [31:0] start, logic [COUNT_WIDTH-1:0] count);
		logic [63:0] v;
		int n;
		bit ok;
		prime_result_t r;
		v = 64'(start) & VALUE_MAX;
		n = (int'(count) > MAX_COUNT) ? MAX_COUNT : int'(count);
		ok = 1'b1;
		if (v != 64'd0) begin
			if (v[0] == 1'b0 && v != 64'd2) v = v + 64'd1;
			while (!passes_six_test(v)) begin
				if (v > VALUE_MAX - 64'd2) begin
					ok = 1'b0;
					break;
				end
				v = v + 64'd2;
			end
		end
		for (int k = 0; k < n; k++) begin
			if (ok) begin
				v = next_prime_after(v);
				ok = (v != 64'd0);
			end
			if (!ok) begin
				r.value = '0;
				r.last = 1'b1;
				r.overflow = 1'b1;
				expected_primes.push_back(r);
				return;
			end
			r.value = v[31:0];
			r.last = (k + 1 == n);
			r.overflow = 1'b0;
			expected_primes.push_back(r);
		end
	endfunction

	// valid stays high across back-to-back requests, so it is lowered only for a gap.
	task automatic send_request(input logic [31:0] start, input logic [COUNT_WIDTH-1:0] count);
		int gap;
		gap = send_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		start_value <= start;
		prime_count <= count;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_run(start, count);
	endtask

	initial begin : result_monitor
		int wait_cycles;
		bit held;
		prime_result_t want;
		held = 1'b0;
		out_ready = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			wait_cycles = recv_idle ? $urandom_range(0, 19) : 0;
			// The long stall is taken once, on the first result after it is asked for.
			if (long_hold && !held) begin
				wait_cycles = wait_cycles + LONG_HOLD_CYCLES;
				held = 1'b1;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				@(posedge clk);
				while (!out_valid) @(posedge clk);
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_primes.size() == 0) begin
				$error("unexpected result: prime_value %0d last %0b overflow %0b",
					prime_value, last, overflow);
				error_count++;
			end else begin
				want = expected_primes.pop_front();
				if (prime_value !== want.value) begin
					$error("prime_value: expected %0d, got %0d", want.value, prime_value);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					error_count++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, overflow);
					error_count++;
				end
			end
		end
	end

	task automatic test_small_starts();
		send_request(32'd0, 7'd5);
		send_request(32'd1, 7'd3);
		send_request(32'd2, 7'd3);
		send_request(32'd3, 7'd2);
		send_request(32'd4, 7'd2);
		send_request(32'd8, 7'd1);
		send_request(32'd24, 7'd2);
		send_request(32'd25, 7'd1);
		send_request(32'd1000, 7'd2);
	endtask

	task automatic test_counts();
		send_request(32'd7, 7'd0);
		send_request(32'd9, 7'd1);
		send_request(32'd0, 7'd64);
		// Counts above the maximum saturate.
		send_request(32'd100, 7'd127);
		send_request(32'd10, 7'd65);
		send_request(32'd5, 7'd63);
	endtask

	// Starts near the top of the range cannot be settled onto a prime.
	task automatic test_overflow();
		send_request(32'hFFFF_FFFF, 7'd3);
		send_request(32'hFFFF_FFFE, 7'd1);
		send_request(32'hFFFF_FFFF, 7'd0);
		send_request(32'hFFFF_FFFE, 7'd127);
	endtask

	// The receiver stalls long enough for the block to hold a result and refuse requests.
	task automatic test_backpressure();
		send_idle = 1'b0;
		long_hold = 1'b1;
		send_request(32'd30, 7'd3);
		send_request(32'd50, 7'd3);
		send_request(32'd70, 7'd3);
		send_request(32'd90, 7'd3);
		send_idle = 1'b1;
	endtask

	task automatic test_random();
		int sel;
		logic [31:0] start;
		logic [COUNT_WIDTH-1:0] count;
		for (int i = 0; i < 80; i++) begin
			send_idle = (i < 30 || i >= 50);
			recv_idle = (i < 30 || i >= 50);
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				start = $urandom_range(0, 1023);
				count = COUNT_WIDTH'($urandom_range(0, 8));
			end else if (sel < 80) begin
				start = $urandom_range(0, 255);
				count = COUNT_WIDTH'($urandom_range(9, 127));
			end else if (sel < 88) begin
				start = $urandom_range(1024, 65535);
				count = COUNT_WIDTH'($urandom_range(1, 2));
			end else if (sel < 91) begin
				start = $urandom_range(65536, 262143);
				count = 7'd1;
			end else if (sel < 96) begin
				start = 32'hFFFF_FFFE | 32'($urandom_range(0, 1));
				count = COUNT_WIDTH'($urandom_range(0, 127));
			end else begin
				start = $urandom_range(0, 1023);
				count = 7'd0;
			end
			send_request(start, count);
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		start_value = '0;
		prime_count = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_starts();
		test_counts();
		test_overflow();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		while (expected_primes.size() != 0) @(posedge clk);
		// Wait until the block is idle again before looking for stray results.
		while (!in_ready) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_primes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/psg_pkg.sv
rtl/psg_datapath.sv
rtl/psg_ctrl.sv
rtl/prime_sequence_generator.sv
sim/prime_sequence_generator_tb.sv
